@@ hdl/tpfc_pkg.sv @@
package tpfc_pkg;

	localparam logic OP_LOAD = 1'b0;

	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_PIXEL_FORMAT = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_USE_MAP      = 1'b1;

	localparam logic [2:0] FMT_PAL16       = 3'd0;
	localparam logic [2:0] FMT_PAL_ALPHA16 = 3'd1;
	localparam logic [2:0] FMT_RGB32       = 3'd2;
	localparam logic [2:0] FMT_ARGB32      = 3'd3;
	localparam logic [2:0] FMT_YUY16       = 3'd4;

	localparam int S_TDATA_W    = 80;
	localparam int M_TDATA_W    = 32;
	localparam int ADDR_FIELD_W = 16;
	localparam int RECIP_SHIFT  = 22;

	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [31:0] ALPHA_OPAQUE   = 32'hff00_0000;
	localparam logic [9:0]  MAP_RED_BASE   = 10'h200;
	localparam logic [9:0]  MAP_GREEN_BASE = 10'h100;

	localparam int YUV_W = 20;
	localparam logic signed [YUV_W-1:0] Y_OFFSET = 20'sd16;
	localparam logic signed [YUV_W-1:0] C_OFFSET = 20'sd128;
	localparam logic signed [YUV_W-1:0] ROUND    = 20'sd128;
	localparam logic signed [YUV_W-1:0] K_Y      = 20'sd298;
	localparam logic signed [YUV_W-1:0] K_RV     = 20'sd409;
	localparam logic signed [YUV_W-1:0] K_GU     = 20'sd100;
	localparam logic signed [YUV_W-1:0] K_GV     = 20'sd208;
	localparam logic signed [YUV_W-1:0] K_BU     = 20'sd516;

	typedef enum logic [2:0] {
		KIND_LOAD   = 3'd0,
		KIND_PAL    = 3'd1,
		KIND_PASS   = 3'd2,
		KIND_RGBMAP = 3'd3,
		KIND_YUV    = 3'd4
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t                kind;
		logic                     force_alpha;
		logic                     luma_map;
		logic                     eol;
		logic [ADDR_FIELD_W-1:0]  addr;
		logic [31:0]              data;
	} cmd_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

	function automatic logic [7:0] clip_channel(input logic signed [YUV_W-1:0] v);
		if (v < 0) begin
			return 8'h00;
		end else if (|v[YUV_W-2:16]) begin
			return 8'hff;
		end else begin
			return v[15:8];
		end
	endfunction

endpackage

@@ hdl/texture_pixel_format_converter_top.sv @@
// Throughput: one item per cycle for palette and unmapped rgb formats while
//   the output is not stalled; a lower rate for yuy16 (two pixels through one
//   output register) and for mapped rgb (three palette reads on a two-read-port
//   memory), which hold the next item back while the current one finishes.
// Reset: clears pipeline valids, queue and config (palette16, no map); palette
//   contents are undefined until loaded, no clearing pass.
module texture_pixel_format_converter_top #(
	parameter int PALETTE_ENTRIES = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tpfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpfc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	// source_word [31:0], entry_index [43:32], entry_value [75:44], zero pad
	input  logic [tpfc_pkg::S_TDATA_W-1:0]       s_tdata,
	// op [0]
	input  logic                                 s_tuser,
	input  logic                                 s_tlast,
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	// argb_pixel [31:0]
	output logic [tpfc_pkg::M_TDATA_W-1:0]       m_tdata,
	// last_of_item [0]
	output logic                                 m_tuser,
	output logic                                 m_tlast
);
	import tpfc_pkg::*;

	logic       push;
	cmd_t       push_cmd;
	logic       pop;
	cmd_t       head;
	fifo_stat_t fifo_stat;

	tpfc_front #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.item_valid  (s_tvalid),
		.item_ready  (s_tready),
		.op          (s_tuser),
		.word        (s_tdata[31:0]),
		.entry_index (s_tdata[43:32]),
		.entry_value (s_tdata[75:44]),
		.eol         (s_tlast),
		.push        (push),
		.push_cmd    (push_cmd),
		.fifo_stat   (fifo_stat)
	);

	tpfc_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.head      (head),
		.fifo_stat (fifo_stat)
	);

	tpfc_back #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.fifo_stat    (fifo_stat),
		.head         (head),
		.pop          (pop),
		.pixel_valid  (m_tvalid),
		.pixel_ready  (m_tready),
		.pixel        (m_tdata),
		.last_of_item (m_tuser),
		.line_end     (m_tlast)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !fifo_stat.full)
		else $error("queue push while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !fifo_stat.empty)
		else $error("queue pop while empty");

	a_pair_second: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && !m_tuser) |=> (m_tvalid && m_tuser))
		else $error("second pixel of pair missing");

	a_line_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser)
		else $error("line end on a non-final pixel");

endmodule

@@ hdl/tpfc_front.sv @@
module tpfc_front #(
	parameter int PALETTE_ENTRIES = 4096
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [tpfc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [tpfc_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                 item_valid,
	output logic                                 item_ready,
	input  logic                                 op,
	input  logic [31:0]                          word,
	input  logic [11:0]                          entry_index,
	input  logic [31:0]                          entry_value,
	input  logic                                 eol,
	output logic                                 push,
	output tpfc_pkg::cmd_t                       push_cmd,
	input  tpfc_pkg::fifo_stat_t                 fifo_stat
);
	import tpfc_pkg::*;

	localparam int AW    = $clog2(PALETTE_ENTRIES);
	localparam int RECIP = (1 << RECIP_SHIFT) / PALETTE_ENTRIES;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PW    = ADDR_FIELD_W + RW;
	localparam int QW    = $clog2(((1 << ADDR_FIELD_W) - 1) / PALETTE_ENTRIES + 2);
	localparam int MW    = ADDR_FIELD_W + 1;

	logic [2:0]              fmt_q;
	logic                    use_map_q;

	cmd_t                    cls;
	logic                    keep;
	logic [ADDR_FIELD_W-1:0] idx_src;
	logic                    adv;

	logic                    valid_s1;
	cmd_t                    cmd_s1;
	logic [ADDR_FIELD_W-1:0] idx_s1;
	logic [PW-1:0]           prod_s1;

	logic [QW-1:0]           quot;
	logic [AW:0]             rem_raw;
	logic [AW:0]             rem;
	cmd_t                    cmd_mod;

	logic                    valid_s2;
	cmd_t                    cmd_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q     <= FMT_PAL16;
			use_map_q <= 1'b0;
		end else if (cfg_we) begin
			if (cfg_index == REG_PIXEL_FORMAT) begin
				fmt_q <= cfg_data;
			end else begin
				use_map_q <= cfg_data[0];
			end
		end
	end

	always_comb begin
		cls         = '0;
		cls.data    = word;
		cls.eol     = eol;
		keep        = 1'b1;
		idx_src     = word[ADDR_FIELD_W-1:0];
		if (op == OP_LOAD) begin
			cls.kind = KIND_LOAD;
			cls.data = entry_value;
			idx_src  = ADDR_FIELD_W'(entry_index);
		end else begin
			unique case (fmt_q)
				FMT_PAL16: begin
					cls.kind        = KIND_PAL;
					cls.force_alpha = 1'b1;
				end
				FMT_PAL_ALPHA16: begin
					cls.kind = KIND_PAL;
				end
				FMT_RGB32: begin
					cls.kind        = use_map_q ? KIND_RGBMAP : KIND_PASS;
					cls.force_alpha = 1'b1;
				end
				FMT_ARGB32: begin
					cls.kind = use_map_q ? KIND_RGBMAP : KIND_PASS;
				end
				FMT_YUY16: begin
					cls.kind     = KIND_YUV;
					cls.luma_map = use_map_q;
				end
				default: begin
					keep = 1'b0;
				end
			endcase
		end
	end

	assign adv        = !valid_s2 || !fifo_stat.full;
	assign item_ready = adv;
	assign push       = valid_s2 && !fifo_stat.full;
	assign push_cmd   = cmd_s2;

	// index mod entry count: reciprocal estimate, then one correction
	always_comb begin
		quot    = QW'(prod_s1 >> RECIP_SHIFT);
		rem_raw = (AW + 1)'(MW'(idx_s1) - MW'(quot) * MW'(PALETTE_ENTRIES));
		rem     = (rem_raw >= (AW + 1)'(PALETTE_ENTRIES)) ?
			rem_raw - (AW + 1)'(PALETTE_ENTRIES) : rem_raw;
		cmd_mod      = cmd_s1;
		cmd_mod.addr = ADDR_FIELD_W'(rem[AW-1:0]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= item_valid && keep;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1  <= cls;
			idx_s1  <= idx_src;
			prod_s1 <= PW'(idx_src) * PW'(RECIP);
			cmd_s2  <= cmd_mod;
		end
	end

endmodule

@@ hdl/tpfc_fifo.sv @@
module tpfc_fifo (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  tpfc_pkg::cmd_t        push_cmd,
	input  logic                  pop,
	output tpfc_pkg::cmd_t        head,
	output tpfc_pkg::fifo_stat_t  fifo_stat
);
	import tpfc_pkg::*;

	cmd_t                  entries_q [FIFO_DEPTH];
	logic [FIFO_PTR_W-1:0] wr_ptr_q;
	logic [FIFO_PTR_W-1:0] rd_ptr_q;
	logic [FIFO_CNT_W-1:0] count_q;

	assign fifo_stat.empty = (count_q == '0);
	assign fifo_stat.full  = (count_q == FIFO_CNT_W'(FIFO_DEPTH));
	assign head            = entries_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

@@ hdl/tpfc_back.sv @@
module tpfc_back #(
	parameter int PALETTE_ENTRIES = 4096
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  tpfc_pkg::fifo_stat_t  fifo_stat,
	input  tpfc_pkg::cmd_t        head,
	output logic                  pop,
	output logic                  pixel_valid,
	input  logic                  pixel_ready,
	output logic [31:0]           pixel,
	output logic                  last_of_item,
	output logic                  line_end
);
	import tpfc_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [31:0]              palette_q [PALETTE_ENTRIES];

	logic                     adv;
	logic                     head_valid;
	logic                     final_step;
	logic                     step_q;
	logic [AW-1:0]            addr_a;
	logic [AW-1:0]            addr_b;

	logic                     valid_s1;
	cmd_t                     cmd_s1;
	logic [31:0]              rd_a_s1;
	logic [31:0]              rd_b_s1;
	logic [31:0]              map_acc_s1;

	logic [7:0]               y0;
	logic [7:0]               y1;
	logic signed [YUV_W-1:0]  c0;
	logic signed [YUV_W-1:0]  c1;
	logic signed [YUV_W-1:0]  d;
	logic signed [YUV_W-1:0]  e;
	logic [31:0]              alpha_or;
	logic [31:0]              alpha_src;
	logic [31:0]              px;

	logic                     valid_s2;
	logic                     yuv_s2;
	logic                     eol_s2;
	logic [31:0]              px_s2;
	logic signed [YUV_W-1:0]  p_c0_s2;
	logic signed [YUV_W-1:0]  p_c1_s2;
	logic signed [YUV_W-1:0]  p_rv_s2;
	logic signed [YUV_W-1:0]  p_gu_s2;
	logic signed [YUV_W-1:0]  p_gv_s2;
	logic signed [YUV_W-1:0]  p_bu_s2;

	logic [31:0]              yuv_pix0;
	logic [31:0]              yuv_pix1;

	logic [1:0]               cnt_q;
	logic [31:0]              pix0_q;
	logic [31:0]              pix1_q;
	logic                     eol_q;

	// pipeline moves when the output register is empty or empties this cycle
	assign adv        = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && pixel_ready);
	assign head_valid = !fifo_stat.empty;
	assign final_step = (head.kind != KIND_RGBMAP) || step_q;
	assign pop        = adv && head_valid && final_step;

	always_comb begin
		addr_a = head.addr[AW-1:0];
		addr_b = head.addr[AW-1:0];
		case (head.kind)
			KIND_RGBMAP: begin
				if (step_q) begin
					addr_a = AW'(head.data[7:0]);
				end else begin
					addr_a = AW'(MAP_RED_BASE + 10'(head.data[23:16]));
					addr_b = AW'(MAP_GREEN_BASE + 10'(head.data[15:8]));
				end
			end
			KIND_YUV: begin
				addr_a = AW'(head.data[15:8]);
				addr_b = AW'(head.data[31:24]);
			end
			default: begin
				addr_a = head.addr[AW-1:0];
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid && (head.kind == KIND_LOAD)) begin
			palette_q[addr_a] <= head.data;
		end
		if (adv) begin
			rd_a_s1 <= palette_q[addr_a];
			rd_b_s1 <= palette_q[addr_b];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q   <= 1'b0;
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (adv) begin
			if (head_valid && (head.kind == KIND_RGBMAP)) begin
				step_q <= !step_q;
			end
			valid_s1 <= pop && (head.kind != KIND_LOAD);
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cmd_s1 <= head;
			if (step_q) begin
				map_acc_s1 <= rd_a_s1 | rd_b_s1;
			end
		end
	end

	always_comb begin
		y0        = cmd_s1.luma_map ? rd_a_s1[7:0] : cmd_s1.data[15:8];
		y1        = cmd_s1.luma_map ? rd_b_s1[7:0] : cmd_s1.data[31:24];
		c0        = $signed(YUV_W'(y0)) - Y_OFFSET;
		c1        = $signed(YUV_W'(y1)) - Y_OFFSET;
		d         = $signed(YUV_W'(cmd_s1.data[7:0])) - C_OFFSET;
		e         = $signed(YUV_W'(cmd_s1.data[23:16])) - C_OFFSET;
		alpha_or  = cmd_s1.force_alpha ? ALPHA_OPAQUE : '0;
		alpha_src = cmd_s1.force_alpha ? ALPHA_OPAQUE : (cmd_s1.data & ALPHA_OPAQUE);
		case (cmd_s1.kind)
			KIND_PAL:    px = alpha_or | rd_a_s1;
			KIND_PASS:   px = alpha_or | cmd_s1.data;
			KIND_RGBMAP: px = alpha_src | map_acc_s1 | rd_a_s1;
			default:     px = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			yuv_s2  <= (cmd_s1.kind == KIND_YUV);
			eol_s2  <= cmd_s1.eol;
			px_s2   <= px;
			p_c0_s2 <= c0 * K_Y;
			p_c1_s2 <= c1 * K_Y;
			p_rv_s2 <= e * K_RV;
			p_gu_s2 <= d * K_GU;
			p_gv_s2 <= e * K_GV;
			p_bu_s2 <= d * K_BU;
		end
	end

	always_comb begin
		yuv_pix0 = {ALPHA_OPAQUE[31:24],
			clip_channel(p_c0_s2 + p_rv_s2 + ROUND),
			clip_channel(p_c0_s2 - p_gu_s2 - p_gv_s2 + ROUND),
			clip_channel(p_c0_s2 + p_bu_s2 + ROUND)};
		yuv_pix1 = {ALPHA_OPAQUE[31:24],
			clip_channel(p_c1_s2 + p_rv_s2 + ROUND),
			clip_channel(p_c1_s2 - p_gu_s2 - p_gv_s2 + ROUND),
			clip_channel(p_c1_s2 + p_bu_s2 + ROUND)};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 2'd0;
		end else if (adv && valid_s2) begin
			cnt_q <= yuv_s2 ? 2'd2 : 2'd1;
		end else if (pixel_valid && pixel_ready) begin
			cnt_q <= cnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			pix0_q <= yuv_pix0;
			pix1_q <= yuv_s2 ? yuv_pix1 : px_s2;
			eol_q  <= eol_s2;
		end
	end

	assign pixel_valid  = (cnt_q != 2'd0);
	assign pixel        = (cnt_q == 2'd2) ? pix0_q : pix1_q;
	assign last_of_item = (cnt_q == 2'd1);
	assign line_end     = (cnt_q == 2'd1) && eol_q;

endmodule

@@ dv/pixel_stream_checker.sv @@
module pixel_stream_checker #(
	parameter int PALETTE_ENTRIES = 4096
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tpfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tpfc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	// source_word [31:0], entry_index [43:32], entry_value [75:44], zero pad
	input  logic [tpfc_pkg::S_TDATA_W-1:0]  s_tdata,
	// op [0]
	input  logic                            s_tuser,
	input  logic                            s_tlast,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// argb_pixel [31:0]
	input  logic [tpfc_pkg::M_TDATA_W-1:0]  m_tdata,
	// last_of_item [0]
	input  logic                            m_tuser,
	input  logic                            m_tlast,
	output int                              errors = 0,
	output int                              pending = 0
);
	import tpfc_pkg::*;

	typedef struct packed {
		logic [31:0] argb;
		logic        item_last;
		logic        line_end;
	} pixel_t;

	logic [31:0] palette_copy [PALETTE_ENTRIES];
	logic [2:0]  fmt;
	logic        map_on;
	pixel_t      pixels_due [$];

	function automatic logic [7:0] saturate(int v);
		if (v < 0) begin
			return 8'h00;
		end
		if ((v >>> 8) > 255) begin
			return 8'hff;
		end
		return 8'(v >>> 8);
	endfunction

	function automatic logic [7:0] luma(logic [7:0] y);
		return map_on ? palette_copy[y][7:0] : y;
	endfunction

	// integer BT.601, floored then clipped per channel
	function automatic logic [31:0] yuv_to_argb(logic [7:0] y, logic [7:0] cb, logic [7:0] cr);
		int c;
		int d;
		int e;
		c = int'(y) - 16;
		d = int'(cb) - 128;
		e = int'(cr) - 128;
		return {8'hff, saturate(298 * c + 409 * e + 128),
			saturate(298 * c - 100 * d - 208 * e + 128),
			saturate(298 * c + 516 * d + 128)};
	endfunction

	function automatic logic [31:0] map_rgb(logic [31:0] w);
		return palette_copy[int'(MAP_RED_BASE) + int'(w[23:16])] |
			palette_copy[int'(MAP_GREEN_BASE) + int'(w[15:8])] |
			palette_copy[int'(w[7:0])];
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [31:0] word;
		pixel_t      got;
		pixel_t      want;
		if (!arst_n) begin
			fmt = FMT_PAL16;
			map_on = 1'b0;
			pixels_due.delete();
			pending = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == REG_PIXEL_FORMAT) begin
					fmt = cfg_data[2:0];
				end else if (cfg_index == REG_USE_MAP) begin
					map_on = cfg_data[0];
				end
			end
			if (m_tvalid && m_tready) begin
				got = pixel_t'({m_tdata[31:0], m_tuser, m_tlast});
				if (pixels_due.size() == 0) begin
					$error("unexpected pixel transaction: argb_pixel %h", got.argb);
					errors++;
				end else begin
					want = pixels_due.pop_front();
					if (got.argb !== want.argb) begin
						$error("argb_pixel: expected %h, actual %h", want.argb, got.argb);
						errors++;
					end
					if (got.item_last !== want.item_last) begin
						$error("last_of_item: expected %b, actual %b",
							want.item_last, got.item_last);
						errors++;
					end
					if (got.line_end !== want.line_end) begin
						$error("line_end: expected %b, actual %b", want.line_end, got.line_end);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				word = s_tdata[31:0];
				if (s_tuser == OP_LOAD) begin
					palette_copy[int'(s_tdata[43:32]) % PALETTE_ENTRIES] = s_tdata[75:44];
				end else begin
					case (fmt)
						FMT_PAL16: begin
							pixels_due.push_back(pixel_t'({ALPHA_OPAQUE |
								palette_copy[int'(word[15:0]) % PALETTE_ENTRIES], 1'b1, s_tlast}));
						end
						FMT_PAL_ALPHA16: begin
							pixels_due.push_back(pixel_t'({
								palette_copy[int'(word[15:0]) % PALETTE_ENTRIES], 1'b1, s_tlast}));
						end
						FMT_RGB32: begin
							pixels_due.push_back(pixel_t'({ALPHA_OPAQUE |
								(map_on ? map_rgb(word) : word), 1'b1, s_tlast}));
						end
						FMT_ARGB32: begin
							pixels_due.push_back(pixel_t'({map_on ?
								((word & ALPHA_OPAQUE) | map_rgb(word)) : word, 1'b1, s_tlast}));
						end
						FMT_YUY16: begin
							pixels_due.push_back(pixel_t'({yuv_to_argb(luma(word[15:8]),
								word[7:0], word[23:16]), 1'b0, 1'b0}));
							pixels_due.push_back(pixel_t'({yuv_to_argb(luma(word[31:24]),
								word[7:0], word[23:16]), 1'b1, s_tlast}));
						end
						default: begin
							// unused format: dropped, nothing comes out
						end
					endcase
				end
			end
			pending = pixels_due.size();
		end
	end

endmodule

@@ dv/testbench.sv @@
module testbench;
	import tpfc_pkg::*;

	localparam int         PALETTE_ENTRIES = 4096;
	localparam logic       OP_CONVERT      = ~OP_LOAD;
	localparam logic [2:0] FMT_UNUSED_LO   = 3'd5;
	localparam logic [2:0] FMT_UNUSED_HI   = 3'd7;
	localparam int         SETTLE_CYCLES   = 12;
	localparam int         CYCLE_LIMIT     = 400000;
	localparam int         PHASES          = 20;
	localparam int         PHASE_ITEMS     = 36;

	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  cfg_we    = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;
	logic                  s_tvalid  = 1'b0;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata   = '0;
	logic                  s_tuser   = 1'b0;
	logic                  s_tlast   = 1'b0;
	logic                  m_tvalid;
	logic                  m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]  m_tdata;
	logic                  m_tuser;
	logic                  m_tlast;

	int errors;
	int pending;
	int idle_pct  = 0;
	int stall_pct = 0;
	int cycles    = 0;
	bit pal_loaded [PALETTE_ENTRIES];

	texture_pixel_format_converter_top #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	pixel_stream_checker #(
		.PALETTE_ENTRIES(PALETTE_ENTRIES)
	) pixel_check (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast),
		.errors(errors),
		.pending(pending)
	);

	always #10 clk = ~clk;

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Some tests failed");
			$finish;
		end
	end

	task automatic send_item(logic op, logic [31:0] word, logic [11:0] idx, logic [31:0] val,
		logic eol);
		@(negedge clk);
		while ($urandom_range(99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= S_TDATA_W'({val, idx, word});
		s_tuser <= op;
		s_tlast <= eol;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
	endtask

	task automatic load_entry(logic [11:0] idx, logic [31:0] val);
		send_item(OP_LOAD, $urandom, idx, val, 1'($urandom_range(1)));
		pal_loaded[idx] = 1'b1;
	endtask

	task automatic convert(logic [31:0] word, logic eol);
		send_item(OP_CONVERT, word, 12'($urandom), $urandom, eol);
	endtask

	// loads and dropped items leave nothing to wait on, so allow for the pipeline too
	task automatic drain();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_mode(logic [2:0] fmt, logic map);
		set_reg(REG_PIXEL_FORMAT, fmt);
		set_reg(REG_USE_MAP, CFG_DATA_W'(map));
	endtask

	// offset of a loaded palette entry within [base, base+span)
	function automatic int pick_loaded(int base, int span);
		int k;
		int start;
		for (k = 0; k < 32; k++) begin
			start = $urandom_range(span - 1);
			if (pal_loaded[base + start]) begin
				return start;
			end
		end
		start = $urandom_range(span - 1);
		for (k = 0; k < span; k++) begin
			if (pal_loaded[base + (start + k) % span]) begin
				return (start + k) % span;
			end
		end
		return 0;
	endfunction

	function automatic logic [31:0] random_word(logic [2:0] fmt, logic map);
		logic [31:0] w;
		w = $urandom;
		case (fmt)
			FMT_PAL16, FMT_PAL_ALPHA16: begin
				w[11:0] = 12'(pick_loaded(0, PALETTE_ENTRIES));
			end
			FMT_RGB32, FMT_ARGB32: begin
				if (map) begin
					w[23:16] = 8'(pick_loaded(int'(MAP_RED_BASE), 256));
					w[15:8] = 8'(pick_loaded(int'(MAP_GREEN_BASE), 256));
					w[7:0] = 8'(pick_loaded(0, 256));
				end
			end
			FMT_YUY16: begin
				if (map) begin
					w[15:8] = 8'(pick_loaded(0, 256));
					w[31:24] = 8'(pick_loaded(0, 256));
				end
			end
			default: begin
			end
		endcase
		return w;
	endfunction

	initial begin : stimulus
		int         p;
		int         i;
		int         n;
		logic [2:0] fmt;
		logic       map;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: map corners, palette extremes, each format, clipping, unused codes
		load_entry(12'h000, 32'h0000_0000);
		load_entry(12'hfff, 32'hffff_ffff);
		load_entry(12'h0ff, $urandom);
		load_entry(12'h100, $urandom);
		load_entry(12'h1ff, $urandom);
		load_entry(12'h200, $urandom);
		load_entry(12'h2ff, $urandom);
		convert(32'h0000_0000, 1'b1);
		convert(32'hffff_ffff, 1'b0);
		set_mode(FMT_PAL_ALPHA16, 1'b1);
		convert(32'h0000_0fff, 1'b1);
		convert(32'hffff_0000, 1'b0);
		set_mode(FMT_RGB32, 1'b0);
		convert(32'hffff_ffff, 1'b1);
		set_reg(REG_USE_MAP, CFG_DATA_W'(1'b1));
		convert(32'hffff_00ff, 1'b0);
		set_reg(REG_PIXEL_FORMAT, FMT_ARGB32);
		convert(32'h12ff_00ff, 1'b1);
		set_reg(REG_USE_MAP, CFG_DATA_W'(1'b0));
		convert(32'h0000_0000, 1'b1);
		set_reg(REG_PIXEL_FORMAT, FMT_YUY16);
		convert(32'hffff_ff00, 1'b1);
		convert(32'h0000_0000, 1'b0);
		set_reg(REG_USE_MAP, CFG_DATA_W'(1'b1));
		convert(32'h00ff_ff00, 1'b1);
		fmt = FMT_UNUSED_LO;
		repeat (int'(FMT_UNUSED_HI) - int'(FMT_UNUSED_LO) + 1) begin
			set_reg(REG_PIXEL_FORMAT, fmt);
			convert($urandom, 1'b1);
			fmt++;
		end

		// random: every format with and without map, under each idle profile, then unused codes
		for (p = 0; p < PHASES + 2; p++) begin
			fmt = (p < PHASES) ? 3'(p % 5) : 3'($urandom_range(FMT_UNUSED_LO, FMT_UNUSED_HI));
			map = 1'((p / 5) % 2);
			set_mode(fmt, map);
			case (p % 4)
				0: begin idle_pct = 0;  stall_pct = 0;  end
				1: begin idle_pct = 73; stall_pct = 0;  end
				2: begin idle_pct = 0;  stall_pct = 73; end
				default: begin idle_pct = 37; stall_pct = 37; end
			endcase
			n = (p < PHASES) ? PHASE_ITEMS : 6;
			for (i = 0; i < n; i++) begin
				if (p % 3 == 0 && i == n / 2) begin
					drain();
				end
				if ($urandom_range(3) == 0) begin
					load_entry($urandom_range(1) ? 12'($urandom_range(12'h2ff)) : 12'($urandom),
						$urandom);
				end else begin
					convert(random_word(fmt, map), $urandom_range(3) == 0);
				end
			end
		end

		drain();
		if (errors == 0 && pending == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

@@ sim.f @@
hdl/tpfc_pkg.sv
hdl/tpfc_front.sv
hdl/tpfc_fifo.sv
hdl/tpfc_back.sv
hdl/texture_pixel_format_converter_top.sv
dv/pixel_stream_checker.sv
dv/testbench.sv
